@@ sv/sacis_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacis_pkg
// Shared types, codes and helpers of the child interval search block.
// ----------------------------------------------------------------------------
package sacis_pkg;

    // input beat opcodes
    localparam logic [1:0] OP_WRITE_TEXT   = 2'd0;
    localparam logic [1:0] OP_WRITE_SUFFIX = 2'd1;
    localparam logic [1:0] OP_QUERY        = 2'd2;

    // register index, taken from the word address
    localparam logic REG_TEXT_LENGTH = 1'b0;
    localparam logic REG_READ_MODE   = 1'b1;

    // read mode bits
    localparam int MODE_REVERSE    = 0;
    localparam int MODE_COMPLEMENT = 1;

    // codes below this are nucleotides and get complemented
    localparam logic [7:0] DNA_CODES = 8'd4;
    localparam logic [7:0] DNA_MAX   = 8'd3;

    typedef struct packed {
        logic [12:0] text_length;
        logic [1:0]  read_mode;
    } t_cfg;

    // requests from the search engine to the stores
    typedef struct packed {
        logic        suf_rd;
        logic [11:0] suf_addr;
        logic        txt_rd;
        logic [12:0] txt_addr;
        logic        suf_wr;
        logic        txt_wr;
        logic [11:0] wr_addr;
        logic [11:0] wr_data;
    } t_mem_req;

    // registered read data from the stores
    typedef struct packed {
        logic [11:0] suf;
        logic [7:0]  txt;
    } t_mem_rsp;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_TEXT = 4'b0010,
        ST_EVAL = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    typedef enum logic [3:0] {
        PH_BOUND_LO = 4'b0001,
        PH_BOUND_HI = 4'b0010,
        PH_FIRST    = 4'b0100,
        PH_LAST     = 4'b1000
    } t_phase;

    // midpoint lo + (hi - lo + 1) / 2, only called with 0 <= lo <= hi
    function automatic logic [11:0] mid_of(logic signed [13:0] lo, logic signed [13:0] hi);
        logic [13:0] span;
        logic [13:0] sum;
        span = 14'($unsigned(hi) - $unsigned(lo)) + 14'd1;
        sum  = $unsigned(lo) + {1'b0, span[13:1]};
        return sum[11:0];
    endfunction

endpackage

@@ sv/sacis_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacis_in_if / sacis_out_if
// Valid/ready channels for input beats and result beats.
// ----------------------------------------------------------------------------
interface sacis_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [11:0] write_index;
    logic [11:0] write_value;
    logic [7:0]  symbol;
    logic [12:0] depth_offset;
    logic [11:0] low_bound;
    logic [11:0] high_bound;

    modport source (output valid, opcode, write_index, write_value, symbol,
                    depth_offset, low_bound, high_bound, input ready);
    modport sink   (input valid, opcode, write_index, write_value, symbol,
                    depth_offset, low_bound, high_bound, output ready);
endinterface

interface sacis_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [11:0] first_index;
    logic [11:0] last_index;

    modport source (output valid, found, first_index, last_index, input ready);
    modport sink   (input valid, found, first_index, last_index, output ready);
endinterface

@@ sv/sacis_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacis_regs
// APB register file holding text length and read mode.
// ----------------------------------------------------------------------------
module sacis_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output sacis_pkg::t_cfg    o_cfg
);

    sacis_pkg::t_cfg r_cfg;
    sacis_pkg::t_cfg n_cfg;
    logic            w_wr;

    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (paddr[2])
                sacis_pkg::REG_TEXT_LENGTH: n_cfg.text_length = pwdata[12:0];
                sacis_pkg::REG_READ_MODE:   n_cfg.read_mode   = pwdata[1:0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            sacis_pkg::REG_TEXT_LENGTH: prdata = {19'd0, r_cfg.text_length};
            sacis_pkg::REG_READ_MODE:   prdata = {30'd0, r_cfg.read_mode};
            default:                    prdata = '0;
        endcase
    end

endmodule

@@ sv/sacis_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacis_mem
// Text store and suffix store, each with separate write and read addresses, registered read.
// ----------------------------------------------------------------------------
module sacis_mem #(
    parameter int unsigned ENTRIES = 4096
) (
    input  logic                 i_clk,
    input  sacis_pkg::t_mem_req  i_req,
    output sacis_pkg::t_mem_rsp  o_rsp
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [7:0]  txt_mem [ENTRIES];
    logic [11:0] suf_mem [ENTRIES];
    logic [7:0]  r_txt_q;
    logic [11:0] r_suf_q;
    logic [31:0] w_suf_rd_ext;
    logic [31:0] w_txt_rd_ext;
    logic [31:0] w_wr_ext;

    assign w_suf_rd_ext = 32'(i_req.suf_addr);
    assign w_txt_rd_ext = 32'(i_req.txt_addr);
    assign w_wr_ext     = 32'(i_req.wr_addr);

    // suffix store
    always_ff @(posedge i_clk) begin
        if (i_req.suf_wr) begin
            suf_mem[w_wr_ext[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.suf_rd) begin
            r_suf_q <= suf_mem[w_suf_rd_ext[AW-1:0]];
        end
    end

    // text store, keeps the low byte of the written value
    always_ff @(posedge i_clk) begin
        if (i_req.txt_wr) begin
            txt_mem[w_wr_ext[AW-1:0]] <= i_req.wr_data[7:0];
        end
        if (i_req.txt_rd) begin
            r_txt_q <= txt_mem[w_txt_rd_ext[AW-1:0]];
        end
    end

    assign o_rsp.suf = r_suf_q;
    assign o_rsp.txt = r_txt_q;

endmodule

@@ sv/sacis_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacis_search
// Sequencer: store writes, boundary probes and the two binary searches.
// ----------------------------------------------------------------------------
module sacis_search #(
    parameter int unsigned ENTRIES        = 4096,
    parameter int unsigned SEPARATOR_CODE = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sacis_pkg::t_cfg      i_cfg,
    sacis_in_if.sink             i_in,
    sacis_out_if.source          o_out,
    output sacis_pkg::t_mem_req  o_req,
    input  sacis_pkg::t_mem_rsp  i_rsp
);

    localparam logic [7:0] SEP = 8'(SEPARATOR_CODE);

    sacis_pkg::t_state r_state, n_state;
    sacis_pkg::t_phase r_phase, n_phase;

    logic [7:0]         r_sym, n_sym;
    logic [12:0]        r_off, n_off;
    logic [11:0]        r_hi_in, n_hi_in;
    logic signed [13:0] r_lo, n_lo;
    logic signed [13:0] r_hi, n_hi;
    logic [11:0]        r_probe, n_probe;
    logic               r_sep, n_sep;
    logic [11:0]        r_hit, n_hit;
    logic               r_hit_ok, n_hit_ok;
    logic [11:0]        r_first, n_first;
    logic               r_res_found, n_res_found;
    logic [11:0]        r_res_first, n_res_first;
    logic [11:0]        r_res_last, n_res_last;
    logic               r_out_valid, n_out_valid;
    logic               r_out_found, n_out_found;
    logic [11:0]        r_out_first, n_out_first;
    logic [11:0]        r_out_last, n_out_last;

    logic        w_acc;
    logic        w_query;
    logic        w_wr_ok;
    logic        w_suf_ok;
    logic [11:0] w_suf_val;
    logic [13:0] w_pos;
    logic [13:0] w_tl;
    logic [13:0] w_rev;
    logic [12:0] w_idx;
    logic        w_sep_pos;
    logic        w_idx_oor;
    logic [7:0]  w_sym_c;
    logic        w_step;
    logic        w_finish;
    logic        w_fin_found;
    logic [11:0] w_fin_first;
    logic [11:0] w_fin_last;

    // input handshake and store writes
    assign i_in.ready = (r_state == sacis_pkg::ST_IDLE);
    assign w_acc      = i_in.valid & i_in.ready;
    assign w_query    = w_acc && (i_in.opcode == sacis_pkg::OP_QUERY);
    assign w_wr_ok    = ({20'd0, i_in.write_index} < 32'(ENTRIES));

    // text position of the suffix just read
    assign w_suf_ok  = ({20'd0, r_probe} < 32'(ENTRIES));
    assign w_suf_val = w_suf_ok ? i_rsp.suf : 12'd0;
    assign w_pos     = {2'b00, w_suf_val} + {1'b0, r_off};
    assign w_tl      = {1'b0, i_cfg.text_length};
    assign w_sep_pos = (w_pos >= w_tl);
    assign w_rev     = w_tl - 14'd1 - w_pos;
    assign w_idx     = i_cfg.read_mode[sacis_pkg::MODE_REVERSE] ? w_rev[12:0] : w_pos[12:0];
    assign w_idx_oor = ({19'd0, w_idx} >= 32'(ENTRIES));

    // probed symbol, separator never complemented
    always_comb begin
        if (r_sep) begin
            w_sym_c = SEP;
        end else if (i_cfg.read_mode[sacis_pkg::MODE_COMPLEMENT]
                     && (i_rsp.txt < sacis_pkg::DNA_CODES)) begin
            w_sym_c = sacis_pkg::DNA_MAX - i_rsp.txt;
        end else begin
            w_sym_c = i_rsp.txt;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_sym       = r_sym;
        n_off       = r_off;
        n_hi_in     = r_hi_in;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_probe     = r_probe;
        n_sep       = r_sep;
        n_hit       = r_hit;
        n_hit_ok    = r_hit_ok;
        n_first     = r_first;
        n_res_found = r_res_found;
        n_res_first = r_res_first;
        n_res_last  = r_res_last;
        n_out_valid = r_out_valid & ~o_out.ready;
        n_out_found = r_out_found;
        n_out_first = r_out_first;
        n_out_last  = r_out_last;
        w_step      = 1'b0;
        w_finish    = 1'b0;
        w_fin_found = 1'b0;
        w_fin_first = 12'd0;
        w_fin_last  = 12'd0;

        o_req          = '0;
        o_req.suf_addr = r_probe;
        o_req.txt_addr = w_idx;
        o_req.wr_addr  = i_in.write_index;
        o_req.wr_data  = i_in.write_value;
        o_req.txt_wr   = w_acc && (i_in.opcode == sacis_pkg::OP_WRITE_TEXT) && w_wr_ok;
        o_req.suf_wr   = w_acc && (i_in.opcode == sacis_pkg::OP_WRITE_SUFFIX) && w_wr_ok;

        unique case (r_state)
            sacis_pkg::ST_IDLE: begin
                if (w_query) begin
                    n_sym          = i_in.symbol;
                    n_off          = i_in.depth_offset;
                    n_hi_in        = i_in.high_bound;
                    n_lo           = $signed({2'b00, i_in.low_bound});
                    n_hi           = $signed({2'b00, i_in.high_bound});
                    n_probe        = i_in.low_bound;
                    n_phase        = sacis_pkg::PH_BOUND_LO;
                    o_req.suf_rd   = 1'b1;
                    o_req.suf_addr = i_in.low_bound;
                    n_state        = sacis_pkg::ST_TEXT;
                end
            end
            sacis_pkg::ST_TEXT: begin
                n_sep        = w_sep_pos | w_idx_oor;
                o_req.txt_rd = 1'b1;
                n_state      = sacis_pkg::ST_EVAL;
            end
            sacis_pkg::ST_EVAL: begin
                unique case (r_phase)
                    sacis_pkg::PH_BOUND_LO: begin
                        if (r_sym < w_sym_c) begin
                            w_finish = 1'b1;
                        end else begin
                            n_phase        = sacis_pkg::PH_BOUND_HI;
                            n_probe        = r_hi_in;
                            o_req.suf_rd   = 1'b1;
                            o_req.suf_addr = r_hi_in;
                            n_state        = sacis_pkg::ST_TEXT;
                        end
                    end
                    sacis_pkg::PH_BOUND_HI: begin
                        if (r_sym > w_sym_c) begin
                            w_finish = 1'b1;
                        end else begin
                            // lo and hi still hold the parent interval
                            n_phase  = sacis_pkg::PH_FIRST;
                            n_hit_ok = 1'b0;
                            w_step   = 1'b1;
                        end
                    end
                    sacis_pkg::PH_FIRST: begin
                        if (w_sym_c < r_sym) begin
                            n_lo = $signed({2'b00, r_probe}) + 14'sd1;
                        end else begin
                            if (w_sym_c == r_sym) begin
                                n_hit    = r_probe;
                                n_hit_ok = 1'b1;
                            end
                            n_hi = $signed({2'b00, r_probe}) - 14'sd1;
                        end
                        // first search done with a hit: search for the last
                        if ((n_lo > n_hi) && n_hit_ok) begin
                            n_first  = n_hit;
                            n_phase  = sacis_pkg::PH_LAST;
                            n_lo     = $signed({2'b00, n_hit}) + 14'sd1;
                            n_hi     = $signed({2'b00, r_hi_in});
                            n_hit_ok = 1'b0;
                        end
                        w_step = 1'b1;
                    end
                    sacis_pkg::PH_LAST: begin
                        if (r_sym < w_sym_c) begin
                            n_hi = $signed({2'b00, r_probe}) - 14'sd1;
                        end else begin
                            if (w_sym_c == r_sym) begin
                                n_hit    = r_probe;
                                n_hit_ok = 1'b1;
                            end
                            n_lo = $signed({2'b00, r_probe}) + 14'sd1;
                        end
                        w_step = 1'b1;
                    end
                    default: w_finish = 1'b1;
                endcase

                // next probe, or the end of the search
                if (w_step) begin
                    if (n_lo <= n_hi) begin
                        n_probe        = sacis_pkg::mid_of(n_lo, n_hi);
                        o_req.suf_rd   = 1'b1;
                        o_req.suf_addr = n_probe;
                        n_state        = sacis_pkg::ST_TEXT;
                    end else if (n_phase == sacis_pkg::PH_LAST) begin
                        w_finish    = 1'b1;
                        w_fin_found = 1'b1;
                        w_fin_first = n_first;
                        w_fin_last  = n_hit_ok ? n_hit : n_first;
                    end else begin
                        w_finish = 1'b1;
                    end
                end

                if (w_finish) begin
                    n_res_found = w_fin_found;
                    n_res_first = w_fin_first;
                    n_res_last  = w_fin_last;
                    n_state     = sacis_pkg::ST_DONE;
                end
            end
            sacis_pkg::ST_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_first = r_res_first;
                    n_out_last  = r_res_last;
                    n_state     = sacis_pkg::ST_IDLE;
                end
            end
            default: n_state = sacis_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sacis_pkg::ST_IDLE;
            r_phase     <= sacis_pkg::PH_BOUND_LO;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_sym       <= n_sym;
        r_off       <= n_off;
        r_hi_in     <= n_hi_in;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_probe     <= n_probe;
        r_sep       <= n_sep;
        r_hit       <= n_hit;
        r_hit_ok    <= n_hit_ok;
        r_first     <= n_first;
        r_res_found <= n_res_found;
        r_res_first <= n_res_first;
        r_res_last  <= n_res_last;
        r_out_found <= n_out_found;
        r_out_first <= n_out_first;
        r_out_last  <= n_out_last;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_out_found;
    assign o_out.first_index = r_out_first;
    assign o_out.last_index  = r_out_last;

endmodule

@@ sv/suffix_array_child_interval_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_array_child_interval_search
// Child interval search over a suffix array held in on-chip stores.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | beat
//  i_in     | in  | valid/ready         | store write or interval query
//  o_out    | out | valid/ready         | found, first_index, last_index
//  apb      | in  | psel/penable/pwrite | text_length (0x0), read_mode (0x4)
//
//  store writes are taken only while no query is in progress; a query does a
//  suffix store read, then a dependent text store read, for each probe, over
//  2 boundary probes and at most 25 search probes for a 4096-entry interval
//  (13 for the first match, 12 for the last); a new beat is taken only after
//  the result has moved into the output register
//  reset clears control state only; the stores are not cleared
//  a finished result waits in the output register while writes keep flowing;
//  the next query result waits in its done state if that register is full
module suffix_array_child_interval_search #(
    parameter int unsigned ENTRIES        = 4096,
    parameter int unsigned SEPARATOR_CODE = 255
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sacis_in_if.sink      i_in,
    sacis_out_if.source   o_out,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    sacis_pkg::t_cfg     w_cfg;
    sacis_pkg::t_mem_req w_req;
    sacis_pkg::t_mem_rsp w_rsp;

    // configuration registers
    sacis_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // text and suffix stores
    sacis_mem #(
        .ENTRIES (ENTRIES)
    ) u_mem (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // search sequencer
    sacis_search #(
        .ENTRIES        (ENTRIES),
        .SEPARATOR_CODE (SEPARATOR_CODE)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_req   (w_req),
        .i_rsp   (w_rsp)
    );

endmodule

@@ sv/sacis_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacis_checker
// Port-level checks of the child interval search block.
// ----------------------------------------------------------------------------
module sacis_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_opcode,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_found,
    input logic [11:0] i_out_first,
    input logic [11:0] i_out_last
);

    // a result beat stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_found) && $stable(i_out_first) && $stable(i_out_last))
        else $error("result payload changed while stalled");

    // a query keeps the input closed on the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_opcode == sacis_pkg::OP_QUERY) |=> !i_in_ready)
        else $error("input open right after a query");

    // a miss reports zero indices
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> (i_out_first == 12'd0) && (i_out_last == 12'd0))
        else $error("miss with non-zero indices");

    // a hit gives an ordered interval
    a_hit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_found |-> (i_out_first <= i_out_last))
        else $error("child interval out of order");

endmodule

bind suffix_array_child_interval_search sacis_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_opcode (i_in.opcode),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_found (o_out.found),
    .i_out_first (o_out.first_index),
    .i_out_last  (o_out.last_index)
);
